### hdl/crc_frame_checker_macros.svh
// assertion macros shared by the crc frame checker rtl
// expects clk and rst_n in the scope of every use
`ifndef CRC_FRAME_CHECKER_MACROS_SVH
`define CRC_FRAME_CHECKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CRCFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CRCFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/crcfc_pkg.sv
// shared types, constants and the byte-wide crc step for the crc frame checker
// no dependencies
`timescale 1ns / 1ps

package crcfc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam int MIN_FRAME_BYTES     = 8;
    localparam int CRC_BYTES           = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0] VERSION_RESET = 8'd1;

    // header byte positions
    localparam int POS_VERSION = 0;
    localparam int POS_NET     = 1;
    localparam int POS_NODE_HI = 2;
    localparam int POS_NODE_LO = 3;
    localparam int POS_TYPE    = 4;
    localparam int POS_SEQ     = 5;
    // first position at which the byte leaving the delay line is payload
    localparam int POS_PAYLOAD_OUT = 8;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_LEN_ERR = 2'd1;
    localparam logic [1:0] STAT_CRC_ERR = 2'd2;
    localparam logic [1:0] STAT_VER_ERR = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int TDATA_PAD = 6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [7:0]  net_id;
        logic [15:0] node_id;
        logic [7:0]  msg_code;
        logic [7:0]  seq;
        logic [7:0]  body_len;
    } result_t;

    // msb-first crc-16 update over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hdl/crcfc_core.sv
// frame state for the crc frame checker: delay line, running crc, byte counter,
// header capture and the per-item result; uses crcfc_pkg and the macros header
`timescale 1ns / 1ps
`include "crc_frame_checker_macros.svh"

module crcfc_core #(
    parameter int MAX_FRAME_BYTES = crcfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_accept,
    input  logic [7:0]          data_byte,
    input  logic                last,
    input  logic [7:0]          expected_version,
    output logic                res_valid,
    output crcfc_pkg::result_t  res
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
    localparam int PW = (CW > 8) ? CW : 9;
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME_BYTES + 1);

    logic [15:0]   crc_reg, crc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    dly0_reg, dly1_reg;
    logic [7:0]    ver_reg, ver_next;
    logic [7:0]    net_reg, net_next;
    logic [15:0]   node_reg, node_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    seq_reg, seq_next;

    logic [15:0]   crc_fed;
    logic [CW-1:0] cnt_inc;
    logic          is_payload;
    logic [15:0]   rx_crc;
    logic [1:0]    status;
    logic [PW-1:0] pl_wide;
    logic [7:0]    pl_len;

    // header capture at arrival
    always_comb
    begin
        ver_next  = ver_reg;
        net_next  = net_reg;
        node_next = node_reg;
        type_next = type_reg;
        seq_next  = seq_reg;
        case (cnt_reg)
            CW'(crcfc_pkg::POS_VERSION): ver_next        = data_byte;
            CW'(crcfc_pkg::POS_NET):     net_next        = data_byte;
            CW'(crcfc_pkg::POS_NODE_HI): node_next[15:8] = data_byte;
            CW'(crcfc_pkg::POS_NODE_LO): node_next[7:0]  = data_byte;
            CW'(crcfc_pkg::POS_TYPE):    type_next       = data_byte;
            CW'(crcfc_pkg::POS_SEQ):     seq_next        = data_byte;
            default:                     ;
        endcase
    end

    // byte leaving the delay line goes into the crc once the line is full
    assign crc_fed    = (cnt_reg >= CW'(crcfc_pkg::CRC_BYTES))
                        ? crcfc_pkg::crc_byte(crc_reg, dly0_reg) : crc_reg;
    assign cnt_inc    = (cnt_reg == CNT_SAT) ? cnt_reg : cnt_reg + CW'(1);
    assign is_payload = (cnt_reg >= CW'(crcfc_pkg::POS_PAYLOAD_OUT));
    assign rx_crc     = {dly1_reg, data_byte};

    assign crc_next = last ? crcfc_pkg::CRC_INIT : crc_fed;
    assign cnt_next = last ? '0 : cnt_inc;

    always_comb
    begin
        if (cnt_inc < CW'(crcfc_pkg::MIN_FRAME_BYTES)
            || cnt_inc > CW'(MAX_FRAME_BYTES))
            status = crcfc_pkg::STAT_LEN_ERR;
        else if (crc_fed != rx_crc)
            status = crcfc_pkg::STAT_CRC_ERR;
        else if (ver_next != expected_version)
            status = crcfc_pkg::STAT_VER_ERR;
        else
            status = crcfc_pkg::STAT_OK;
    end

    assign pl_wide = PW'(cnt_inc) - PW'(crcfc_pkg::MIN_FRAME_BYTES);
    assign pl_len  = (pl_wide > PW'(255)) ? 8'hFF : pl_wide[7:0];

    always_comb
    begin
        res              = '0;
        res.payload_byte = is_payload ? dly0_reg : 8'h00;
        if (last)
        begin
            res.kind   = crcfc_pkg::KIND_STATUS;
            res.status = status;
            if (status == crcfc_pkg::STAT_OK)
            begin
                res.net_id   = net_next;
                res.node_id  = node_next;
                res.msg_code = type_next;
                res.seq      = seq_next;
                res.body_len = pl_len;
            end
        end
        else
        begin
            res.kind = crcfc_pkg::KIND_PAYLOAD;
        end
    end

    assign res_valid = in_accept && (last || is_payload);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= crcfc_pkg::CRC_INIT;
            cnt_reg  <= '0;
            dly0_reg <= '0;
            dly1_reg <= '0;
            ver_reg  <= '0;
            net_reg  <= '0;
            node_reg <= '0;
            type_reg <= '0;
            seq_reg  <= '0;
        end
        else if (in_accept)
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            dly0_reg <= dly1_reg;
            dly1_reg <= data_byte;
            ver_reg  <= ver_next;
            net_reg  <= net_next;
            node_reg <= node_next;
            type_reg <= type_next;
            seq_reg  <= seq_next;
        end
    end

    // frame state restarts after the last byte
    `CRCFC_ASSERT_NEXT(a_frame_restart, in_accept && last,
        cnt_reg == '0 && crc_reg == crcfc_pkg::CRC_INIT, "frame state not restarted")
    // counter never runs past saturation
    `CRCFC_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CNT_SAT, "byte counter past saturation")

endmodule

### hdl/crc_frame_checker.sv
// top level of the crc frame checker: stream ports, version register, result register
// depends on crcfc_pkg, crcfc_core and the macros header
`timescale 1ns / 1ps
`include "crc_frame_checker_macros.svh"

// channel     | direction | handshake                     | payload
// ------------+-----------+-------------------------------+-------------------------------------
// s_axis      | in        | s_axis_tvalid / s_axis_tready | tdata: data_byte; tlast: last
// m_axis      | out       | m_axis_tvalid / m_axis_tready | tuser: kind; tdata: result fields
// cfg         | in        | cfg_wr_en                     | cfg_wr_data: expected_version
//
// one item per cycle while not stalled; a result appears on m_axis the cycle after its item
// payload bytes come out two items after they arrive; the last item gives a status item
// the crc update is a byte-wide eight-step xor network in front of the result register
// reset clears the frame state, sets the expected version to 1 and empties the output
// s_axis_tready drops only while a result waits in the output register and m_axis stalls

module crc_frame_checker #(
    parameter int MAX_FRAME_BYTES = crcfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last byte of the frame
    // result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] status, [17:10] net_id,
                                        // [33:18] node_id, [41:34] msg_code, [49:42] seq,
                                        // [57:50] body_len, [63:58] zero
    output logic        m_axis_tuser,   // [0] kind
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data     // expected_version
);

    logic               in_accept;
    logic               core_valid;
    crcfc_pkg::result_t core_res;

    logic               out_valid_reg;
    crcfc_pkg::result_t out_res_reg;
    logic [7:0]         version_reg;

    // the output register frees up in the same cycle it is taken
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    crcfc_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_accept        (in_accept),
        .data_byte        (s_axis_tdata),
        .last             (s_axis_tlast),
        .expected_version (version_reg),
        .res_valid        (core_valid),
        .res              (core_res)
    );

    // expected protocol version
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            version_reg <= crcfc_pkg::VERSION_RESET;
        else if (cfg_wr_en)
            version_reg <= cfg_wr_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_valid)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {{crcfc_pkg::TDATA_PAD{1'b0}},
                            out_res_reg.body_len,
                            out_res_reg.seq,
                            out_res_reg.msg_code,
                            out_res_reg.node_id,
                            out_res_reg.net_id,
                            out_res_reg.status,
                            out_res_reg.payload_byte};

    // a last byte always yields a status item next cycle
    `CRCFC_ASSERT_NEXT(a_last_gives_status, in_accept && s_axis_tlast,
        m_axis_tvalid && m_axis_tuser == crcfc_pkg::KIND_STATUS, "missing status item")
    // header fields and length are hidden unless the frame is good
    `CRCFC_ASSERT_SAME(a_err_fields_zero,
        m_axis_tvalid && out_res_reg.status != crcfc_pkg::STAT_OK,
        m_axis_tdata[57:10] == '0, "header fields leak on error")
    // payload items carry no status
    `CRCFC_ASSERT_SAME(a_payload_no_status,
        m_axis_tvalid && m_axis_tuser == crcfc_pkg::KIND_PAYLOAD,
        m_axis_tdata[57:8] == '0, "payload item carries status fields")

endmodule
